// ----- hdl/pmq_pkg.sv -----
// ----------------------------------------------------------------------------
// pmq_pkg: shared types and constants of the priority message queue
// Queue depth, field widths, operation codes and the structs that pass
// along the row of storage cells.
// ----------------------------------------------------------------------------
package pmq_pkg;

	localparam int DEPTH = 64;
	localparam int PAY_W = 32;
	localparam int PRI_W = 2;
	localparam int NUM_PRI = 1 << PRI_W;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_REPLACE = 2'd1;
	localparam logic [1:0] OP_TAKE    = 2'd2;

	// operation broadcast to every cell for the length of one walk
	typedef struct packed {
		logic [1:0]       op;
		logic [PAY_W-1:0] pay;
		logic [PRI_W-1:0] pri;
	} cmd_t;

	// token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic             go;
		logic             found;
		logic [PAY_W-1:0] pay;
		logic [PRI_W-1:0] pri;
	} tok_t;

	// contents of one cell
	typedef struct packed {
		logic             valid;
		logic [PAY_W-1:0] pay;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// one result word
	typedef struct packed {
		logic             ok;
		logic             replaced;
		logic [PAY_W-1:0] pay;
		logic [PRI_W-1:0] pri;
		logic [CNT_W-1:0] occ;
	} res_t;

endpackage

// ----- hdl/priority_message_queue_top.sv -----
// ----------------------------------------------------------------------------
// priority_message_queue_top: bounded priority queue with replacement
// Entries are kept oldest first in a row of cells; a token walks the row.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one request word: mode 0
// enqueues payload with priority_req, mode 1 dequeues the oldest entry of
// the highest priority held. The output channel (out_valid/out_ready)
// returns exactly one result word per request: ok, replaced, out_payload,
// out_priority and the occupancy after the operation.
// Every request walks a token through all DEPTH cells, one cell a cycle,
// and the result word is registered once the token leaves the last cell;
// one request is in work at a time, and the next one can be taken from
// the cycle after the walk ends, unless a finished result is held back.
// A full queue turns an enqueue into a search for the oldest entry of
// lower priority, which is overwritten; a dequeue compacts the later
// entries down one cell as the token passes.
// Reset empties the queue at once. While the receiver stalls, one finished
// result waits in a holding register and the output word stays put;
// further requests are refused until the holding register drains.
// ----------------------------------------------------------------------------
module priority_message_queue_top import pmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             mode,
	input  logic [PAY_W-1:0] payload,
	input  logic [PRI_W-1:0] priority_req,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             ok,
	output logic             replaced,
	output logic [PAY_W-1:0] out_payload,
	output logic [PRI_W-1:0] out_priority,
	output logic [CNT_W-1:0] occupancy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic             state_q;
	logic             start_q;
	cmd_t             cmd_q;
	cmd_t             cmd_d;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] occ_d;
	logic [CNT_W-1:0] cnt_q [NUM_PRI];
	logic [NUM_PRI-1:0] cnt_inc;
	logic [NUM_PRI-1:0] cnt_dec;
	logic [PRI_W-1:0] top_pri;
	logic             out_valid_q;
	logic             pend_q;
	res_t             out_q;
	res_t             pend_r_q;
	res_t             res_d;
	logic             acc;
	logic             done;
	logic             out_free;
	tok_t             last;

	tok_t   tok [DEPTH+1];
	entry_t ent [DEPTH+1];

	assign tok[0] = '{go: start_q, found: 1'b0, pay: '0, pri: '0};
	assign ent[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		pmq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd_q),
			.tok_in  (tok[i]),
			.nxt     (ent[i+1]),
			.ent     (ent[i]),
			.tok_out (tok[i+1])
		);
	end

	assign last     = tok[DEPTH];
	assign done     = last.go;
	assign in_ready = (state_q == ST_IDLE) && !pend_q;
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// highest priority present, from the per-priority counts
	always_comb begin
		top_pri = '0;
		for (int p = 0; p < NUM_PRI; p++) begin
			if (cnt_q[p] != '0) begin
				top_pri = PRI_W'(p);
			end
		end
	end

	always_comb begin
		cmd_d.pay = payload;
		if (mode) begin
			cmd_d.op  = OP_TAKE;
			cmd_d.pri = top_pri;
		end else begin
			cmd_d.op  = (occ_q == CNT_W'(DEPTH)) ? OP_REPLACE : OP_APPEND;
			cmd_d.pri = priority_req;
		end
	end

	always_comb begin
		cnt_inc = '0;
		cnt_dec = '0;
		occ_d   = occ_q;
		if (done && last.found) begin
			unique case (cmd_q.op)
				OP_APPEND: begin
					cnt_inc[cmd_q.pri] = 1'b1;
					occ_d = occ_q + CNT_W'(1);
				end
				OP_REPLACE: begin
					cnt_inc[cmd_q.pri] = 1'b1;
					cnt_dec[last.pri]  = 1'b1;
				end
				OP_TAKE: begin
					cnt_dec[last.pri] = 1'b1;
					occ_d = occ_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res_d.ok       = last.found;
		res_d.replaced = last.found && (cmd_q.op == OP_REPLACE);
		res_d.pay      = (last.found && cmd_q.op == OP_TAKE) ? last.pay : '0;
		res_d.pri      = (last.found && cmd_q.op == OP_TAKE) ? last.pri : '0;
		res_d.occ      = occ_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			for (int p = 0; p < NUM_PRI; p++) begin
				cnt_q[p] <= '0;
			end
		end else begin
			start_q <= acc;
			if (acc) begin
				state_q <= ST_WALK;
			end else if (done) begin
				state_q <= ST_IDLE;
			end
			occ_q <= occ_d;
			for (int p = 0; p < NUM_PRI; p++) begin
				cnt_q[p] <= cnt_q[p] + CNT_W'(cnt_inc[p]) - CNT_W'(cnt_dec[p]);
			end
			// hold a finished word while the receiver stalls
			if (done && !out_free) begin
				pend_q <= 1'b1;
			end else if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end
			if ((done || pend_q) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= cmd_d;
		end
		if (done && !out_free) begin
			pend_r_q <= res_d;
		end
		if (done && out_free) begin
			out_q <= res_d;
		end else if (pend_q && out_free) begin
			out_q <= pend_r_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = out_q.ok;
	assign replaced     = out_q.replaced;
	assign out_payload  = out_q.pay;
	assign out_priority = out_q.pri;
	assign occupancy    = out_q.occ;

`ifndef SYNTHESIS
	a_accept_walks: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_WALK))
		else $error("accepted request did not start a walk");

	a_done_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_WALK))
		else $error("token left the row outside a walk");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_cnt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		((CNT_W+PRI_W)'(cnt_q[0]) + (CNT_W+PRI_W)'(cnt_q[1]) + (CNT_W+PRI_W)'(cnt_q[2])
			+ (CNT_W+PRI_W)'(cnt_q[3])) == (CNT_W+PRI_W)'(occ_q))
		else $error("priority counts disagree with occupancy");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("held word without a word on the output");
`endif

endmodule

// ----- hdl/pmq_cell.sv -----
// ----------------------------------------------------------------------------
// pmq_cell: one storage cell of the priority message queue
// Holds one entry. When the token reaches it, it appends, replaces, hands
// its entry out, or pulls the entry of its upper neighbor down one place.
// ----------------------------------------------------------------------------
module pmq_cell import pmq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  tok_t   tok_in,
	input  entry_t nxt,
	output entry_t ent,
	output tok_t   tok_out
);

	entry_t ent_q;
	tok_t   tok_q;
	tok_t   tok_d;
	logic   load_cmd;
	logic   take_next;

	always_comb begin
		tok_d     = tok_in;
		load_cmd  = 1'b0;
		take_next = 1'b0;
		if (tok_in.go) begin
			unique case (cmd.op)
				OP_APPEND: begin
					// first empty cell takes the word
					if (!tok_in.found && !ent_q.valid) begin
						load_cmd    = 1'b1;
						tok_d.found = 1'b1;
					end
				end
				OP_REPLACE: begin
					if (!tok_in.found && ent_q.valid && (ent_q.pri < cmd.pri)) begin
						load_cmd    = 1'b1;
						tok_d.found = 1'b1;
						tok_d.pri   = ent_q.pri;
					end
				end
				OP_TAKE: begin
					if (tok_in.found) begin
						take_next = 1'b1;
					end else if (ent_q.valid && (ent_q.pri == cmd.pri)) begin
						take_next   = 1'b1;
						tok_d.found = 1'b1;
						tok_d.pay   = ent_q.pay;
						tok_d.pri   = ent_q.pri;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (load_cmd) begin
				ent_q.valid <= 1'b1;
				ent_q.pay   <= cmd.pay;
				ent_q.pri   <= cmd.pri;
			end else if (take_next) begin
				ent_q <= nxt;
			end
		end
	end

	assign ent     = ent_q;
	assign tok_out = tok_q;

endmodule

// ----- bench/priority_message_queue_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_message_queue_top_test: self-checking bench for the priority queue
// Keeps a shadow copy of the ring and predicts one result word per request.
// A directed opening covers empty dequeues, priority order and compaction.
// Random bursts then fill, drain and overload the ring, so that replacement
// and dropped enqueues in a full ring both get exercised. Both channels idle
// at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module priority_message_queue_top_test;
	import pmq_pkg::*;

	localparam logic        MODE_ENQ     = 1'b0;
	localparam logic        MODE_DEQ     = 1'b1;
	localparam int unsigned RANDOM_ITEMS = 1435;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned MAX_REPORTS  = 40;

	typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_URGENT} burst_style_t;

	// shadow ring: predicts the result word of every accepted request
	class priority_shadow_t;
		bit [PAY_W-1:0] slot_pay[DEPTH];
		bit [PRI_W-1:0] slot_pri[DEPTH];
		int unsigned    head_idx;
		int unsigned    tail_idx;
		int unsigned    held;
		res_t           pending_results[$];
		int unsigned    errors;

		function void log_request(logic m, logic [PAY_W-1:0] p, logic [PRI_W-1:0] q);
			res_t           r;
			int unsigned    pos;
			int unsigned    nx;
			int unsigned    best;
			bit [PRI_W-1:0] best_pri;
			r = '0;
			if (m == MODE_ENQ) begin
				if (held >= DEPTH) begin
					// full: overwrite the oldest strictly lower entry, else drop
					pos = head_idx;
					for (int i = 0; i < DEPTH && !r.ok; i++) begin
						if (slot_pri[pos] < q) begin
							slot_pay[pos] = p;
							slot_pri[pos] = q;
							r.ok = 1'b1;
							r.replaced = 1'b1;
						end
						pos = (pos + 1) % DEPTH;
					end
				end else begin
					slot_pay[tail_idx] = p;
					slot_pri[tail_idx] = q;
					tail_idx = (tail_idx + 1) % DEPTH;
					held++;
					r.ok = 1'b1;
				end
			end else if (held != 0) begin
				best = head_idx;
				best_pri = slot_pri[head_idx];
				pos = head_idx;
				for (int i = 1; i < held; i++) begin
					pos = (pos + 1) % DEPTH;
					if (slot_pri[pos] > best_pri) begin
						best_pri = slot_pri[pos];
						best = pos;
					end
				end
				r.ok = 1'b1;
				r.pay = slot_pay[best];
				r.pri = best_pri;
				if (best == head_idx) begin
					head_idx = (head_idx + 1) % DEPTH;
				end else begin
					// close the gap: later entries move down one slot
					pos = best;
					nx = (pos + 1) % DEPTH;
					while (nx != tail_idx) begin
						slot_pay[pos] = slot_pay[nx];
						slot_pri[pos] = slot_pri[nx];
						pos = nx;
						nx = (pos + 1) % DEPTH;
					end
					tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
				end
				held--;
			end
			r.occ = held[CNT_W-1:0];
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result word, expected none, actual %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("ok", want.ok, got.ok);
			compare_field("replaced", want.replaced, got.replaced);
			compare_field("out_payload", want.pay, got.pay);
			compare_field("out_priority", want.pri, got.pri);
			compare_field("occupancy", want.occ, got.occ);
		endfunction
	endclass

	logic             clk;
	logic             arst_n       = 1'b0;
	logic             in_valid     = 1'b0;
	logic             in_ready;
	logic             mode         = MODE_ENQ;
	logic [PAY_W-1:0] payload      = '0;
	logic [PRI_W-1:0] priority_req = '0;
	logic             out_valid;
	logic             out_ready    = 1'b0;
	logic             ok;
	logic             replaced;
	logic [PAY_W-1:0] out_payload;
	logic [PRI_W-1:0] out_priority;
	logic [CNT_W-1:0] occupancy;

	priority_shadow_t sb = new;

	int unsigned tx_left  = 0;
	bit          tx_quiet = 1'b0;
	int unsigned rx_left  = 0;
	bit          rx_quiet = 1'b0;
	int unsigned idle_cycles = 0;

	priority_message_queue_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.payload      (payload),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ok           (ok),
		.replaced     (replaced),
		.out_payload  (out_payload),
		.out_priority (out_priority),
		.occupancy    (occupancy)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// wait length for one word; quiet stretches draw no wait at all
	function automatic int unsigned draw_wait(inout int unsigned left, inout bit quiet);
		if (left == 0) begin
			left = $urandom_range(8, 60);
			quiet = ($urandom_range(0, 3) == 0);
		end
		left--;
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic m, input logic [PAY_W-1:0] p,
		input logic [PRI_W-1:0] q);
		int unsigned gap;
		gap = draw_wait(tx_left, tx_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		payload <= p;
		priority_req <= q;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.log_request(m, p, q);
		@(negedge clk);
	endtask

	// receiver: stall either right away or once a result word is waiting
	initial begin
		int unsigned stall;
		bit          late;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait(rx_left, rx_quiet);
			late = 1'($urandom_range(0, 1));
			if (stall > 0) begin
				out_ready <= 1'b0;
				if (late) begin
					do begin
						@(posedge clk);
					end while (!out_valid);
					@(negedge clk);
				end
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({ok, replaced, out_payload, out_priority, occupancy});
	end

	// watchdog: end the run if no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned      sent;
		int unsigned      burst;
		int unsigned      enq_pct;
		burst_style_t     style;
		logic [PRI_W-1:0] pri;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty dequeue, field extremes, priority order, compaction
		send_request(MODE_DEQ, 32'hFFFF_FFFF, 2'd3);
		send_request(MODE_ENQ, 32'h0000_0000, 2'd0);
		send_request(MODE_ENQ, 32'hFFFF_FFFF, 2'd3);
		send_request(MODE_ENQ, 32'h5A5A_5A5A, 2'd1);
		send_request(MODE_ENQ, 32'hA5A5_A5A5, 2'd2);
		send_request(MODE_ENQ, 32'h0000_0001, 2'd3);
		send_request(MODE_DEQ, 32'h0, 2'd0);
		send_request(MODE_DEQ, 32'h0, 2'd0);
		send_request(MODE_DEQ, 32'h0, 2'd0);
		send_request(MODE_DEQ, 32'h0, 2'd0);
		send_request(MODE_DEQ, 32'h0, 2'd0);
		send_request(MODE_DEQ, 32'h1234_5678, 2'd2);
		send_request(MODE_ENQ, 32'h0000_0AAA, 2'd2);
		send_request(MODE_ENQ, 32'h0000_0BBB, 2'd2);
		send_request(MODE_DEQ, 32'h0, 2'd0);
		send_request(MODE_DEQ, 32'h0, 2'd0);

		// random bursts: fill and overload the ring, drain it, or mix
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(20, 90);
			style = burst_style_t'($urandom_range(0, 3));
			case (style)
				BURST_FILL:   enq_pct = 90;
				BURST_DRAIN:  enq_pct = 15;
				BURST_MIXED:  enq_pct = 55;
				default:      enq_pct = 92;
			endcase
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if (style == BURST_URGENT && $urandom_range(0, 99) < 80)
					pri = 2'd3;
				else
					pri = PRI_W'($urandom_range(0, 3));
				if ($urandom_range(0, 99) < enq_pct)
					send_request(MODE_ENQ, $urandom, pri);
				else
					send_request(MODE_DEQ, $urandom, pri);
				sent++;
			end
		end
		in_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/pmq_pkg.sv
hdl/pmq_cell.sv
hdl/priority_message_queue_top.sv
bench/priority_message_queue_top_test.sv
